FILE: hw/rtl/three_axis_step_pulse_generator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three-axis step pulse generator
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef THREE_AXIS_STEP_PULSE_GENERATOR_ASSERT_SVH
`define THREE_AXIS_STEP_PULSE_GENERATOR_ASSERT_SVH

// consequent in the cycle after the antecedent
`define TASP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tasp: assertion failed");

// consequent in the same cycle as the antecedent
`define TASP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tasp: assertion failed");

`endif

FILE: hw/rtl/tasp_pkg.sv
// ---------------------------------------------------------------------------
// tasp_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package tasp_pkg;

    localparam int TIME_BITS  = 32;
    localparam int STEP_BITS  = 16;
    localparam int AXES       = 3;
    localparam int SPEED_BITS = 15;

    localparam int AXIS_W   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int BIT_W    = $clog2(TIME_BITS);
    localparam int CMP_BITS = (STEP_BITS > SPEED_BITS) ? STEP_BITS : SPEED_BITS;

    localparam int IN_TDATA_W  = ((AXES * STEP_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS  = 3 * AXES;
    localparam int OUT_TDATA_W = ((OUT_FIELDS + 7) / 8) * 8;

    localparam logic [SPEED_BITS-1:0] SPEED_LIMIT_RESET = SPEED_BITS'(2000);

    // input op codes, carried on s_axis_tuser
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    typedef struct packed {
        logic              load_tick;
        logic              load_cmd;
        logic              tick_axes;
        logic              div_load;
        logic              div_step;
        logic              div_write;
        logic [AXIS_W-1:0] axis;
        logic              out_load;
    } tasp_cmd_t;

    typedef struct packed {
        logic out_free;
    } tasp_stat_t;

endpackage

FILE: hw/rtl/tasp_ctrl.sv
// ---------------------------------------------------------------------------
// tasp_ctrl
// Sequencer: tick update, per-axis period division, result hand-off.
// ---------------------------------------------------------------------------
module tasp_ctrl import tasp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_op,
    input  tasp_stat_t stat,
    output logic       in_ready,
    output tasp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_COMMAND)
                    begin
                        cmd.load_cmd = 1'b1;
                        axis_next    = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        cmd.load_tick = 1'b1;
                        state_next    = ST_TICK;
                    end
                end
            end
            ST_TICK:
            begin
                cmd.tick_axes = 1'b1;
                state_next    = ST_DONE;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                bit_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == BIT_W'(TIME_BITS - 1))
                    state_next = ST_WRITE;
                else
                    bit_next = bit_reg + 1'b1;
            end
            ST_WRITE:
            begin
                cmd.div_write = 1'b1;
                if (axis_reg == AXIS_W'(AXES - 1))
                    state_next = ST_DONE;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

FILE: hw/rtl/tasp_datapath.sv
// ---------------------------------------------------------------------------
// tasp_datapath
// Axis state, elapsed/frame timers, shared restoring divider, result register.
// ---------------------------------------------------------------------------
module tasp_datapath import tasp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tasp_cmd_t                   cmd,
    input  logic [AXES*STEP_BITS-1:0]   in_steps,
    input  logic                        cfg_we,
    input  logic [SPEED_BITS-1:0]       cfg_wdata,
    input  logic                        out_ready,
    output tasp_stat_t                  stat,
    output logic                        out_valid,
    output logic [OUT_TDATA_W-1:0]      out_data
);

    logic [SPEED_BITS-1:0] speed_limit_reg, speed_limit_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]  frame_reg, frame_next;
    logic [TIME_BITS-1:0]  period_reg [AXES];
    logic [TIME_BITS-1:0]  period_next [AXES];
    logic [TIME_BITS-1:0]  phase_reg [AXES];
    logic [TIME_BITS-1:0]  phase_next [AXES];
    logic [AXES-1:0]       level_reg, level_next;
    logic [AXES-1:0]       dir_reg, dir_next;
    logic [AXES-1:0]       run_reg, run_next;
    logic [SPEED_BITS-1:0] mag_reg [AXES];
    logic [SPEED_BITS-1:0] mag_next [AXES];
    logic [TIME_BITS-1:0]  quot_reg, quot_next;
    logic [SPEED_BITS-1:0] rem_reg, rem_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // per-axis helpers
    logic [STEP_BITS-1:0]  raw_w   [AXES];
    logic [STEP_BITS-1:0]  abs_w   [AXES];
    logic [SPEED_BITS-1:0] clamp_w [AXES];
    logic [TIME_BITS-1:0]  inc_w   [AXES];
    logic [AXES-1:0]       hit_w;
    logic                  timeout_w;
    logic [SPEED_BITS:0]   shifted_w;
    logic [SPEED_BITS:0]   diff_w;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            raw_w[a] = in_steps[a*STEP_BITS +: STEP_BITS];
            abs_w[a] = raw_w[a][STEP_BITS-1] ? (STEP_BITS'(0) - raw_w[a]) : raw_w[a];
            if (CMP_BITS'(abs_w[a]) > CMP_BITS'(speed_limit_reg))
                clamp_w[a] = speed_limit_reg;
            else
                clamp_w[a] = SPEED_BITS'(abs_w[a]);
            inc_w[a] = phase_reg[a] + 1'b1;
            hit_w[a] = (inc_w[a] >= period_reg[a]);
        end
    end

    // elapsed > 2 * frame
    assign timeout_w = ({1'b0, elapsed_reg} > {frame_reg, 1'b0});

    // one restoring divide step
    assign shifted_w = {rem_reg, quot_reg[TIME_BITS-1]};
    assign diff_w    = shifted_w - {1'b0, mag_reg[cmd.axis]};

    always_comb
    begin
        logic stopped;
        stopped          = 1'b0;
        speed_limit_next = speed_limit_reg;
        elapsed_next     = elapsed_reg;
        frame_next       = frame_reg;
        period_next      = period_reg;
        phase_next       = phase_reg;
        level_next       = level_reg;
        dir_next         = dir_reg;
        run_next         = run_reg;
        mag_next         = mag_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;

        if (cfg_we)
            speed_limit_next = cfg_wdata;

        if (cmd.load_tick)
        begin
            if (elapsed_reg != '1)
                elapsed_next = elapsed_reg + 1'b1;
        end

        if (cmd.load_cmd)
        begin
            frame_next   = elapsed_reg;
            elapsed_next = '0;
            for (int a = 0; a < AXES; a++)
            begin
                dir_next[a]   = raw_w[a][STEP_BITS-1];
                mag_next[a]   = clamp_w[a];
                run_next[a]   = (clamp_w[a] != '0);
                phase_next[a] = '0;
            end
        end

        // axes in order; the first toggle that finds a timeout stops all axes, later ones skip the tick
        if (cmd.tick_axes)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (run_reg[a] && !stopped)
                begin
                    phase_next[a] = hit_w[a] ? '0 : inc_w[a];
                    if (hit_w[a])
                    begin
                        level_next[a] = ~level_reg[a];
                        if (timeout_w)
                            stopped = 1'b1;
                    end
                end
            end
            if (stopped)
                run_next = '0;
        end

        if (cmd.div_load)
        begin
            quot_next = frame_reg;
            rem_next  = '0;
        end

        if (cmd.div_step)
        begin
            if (!diff_w[SPEED_BITS])
            begin
                rem_next  = diff_w[SPEED_BITS-1:0];
                quot_next = {quot_reg[TIME_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted_w[SPEED_BITS-1:0];
                quot_next = {quot_reg[TIME_BITS-2:0], 1'b0};
            end
        end

        if (cmd.div_write)
            period_next[cmd.axis] = (quot_reg == '0) ? TIME_BITS'(1) : quot_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_TDATA_W'({run_reg, dir_reg, level_reg});
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= SPEED_LIMIT_RESET;
            elapsed_reg     <= '0;
            frame_reg       <= '0;
            level_reg       <= '0;
            dir_reg         <= '0;
            run_reg         <= '0;
            out_valid_reg   <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                period_reg[a] <= '0;
                phase_reg[a]  <= '0;
            end
        end
        else
        begin
            speed_limit_reg <= speed_limit_next;
            elapsed_reg     <= elapsed_next;
            frame_reg       <= frame_next;
            level_reg       <= level_next;
            dir_reg         <= dir_next;
            run_reg         <= run_next;
            out_valid_reg   <= out_valid_next;
            period_reg      <= period_next;
            phase_reg       <= phase_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

FILE: hw/rtl/three_axis_step_pulse_generator.sv
// ---------------------------------------------------------------------------
// three_axis_step_pulse_generator
// Step/direction pulse generator for three axes, one result per input transfer.
// ---------------------------------------------------------------------------
// Each input transfer is either a one-microsecond tick (tuser = 0) or a step
// command (tuser = 1) carrying signed step counts for x, y and z. A command
// latches the ticks counted since the previous command as the frame length,
// sets each direction pin from the sign, clamps the magnitude to speed_limit
// and starts every axis with a nonzero magnitude at a toggle period of
// max(1, frame / magnitude); zero-step axes stop. On a tick every running axis
// advances its phase counter and toggles its step pin when the period is
// reached; a toggle that finds more than twice the frame length gone since the
// command stops all axes (axes evaluated x, y, z). Every transfer returns the
// pin levels after it.
// A tick passes through the tick and done states; a command loads, divides
// and writes each axis period in turn on the single shared restoring divider,
// one quotient bit per cycle (32 steps plus load and write per axis). A result
// sits in the output register until taken; the block accepts the next transfer
// meanwhile and holds the following result until the register frees up.
// speed_limit resets to 2000 and is written through the cfg channel (always
// ready); the user writes it only while the block is idle, as it is not enforced.
// ---------------------------------------------------------------------------
module three_axis_step_pulse_generator import tasp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // steps_x, steps_y, steps_z
    input  logic                   s_axis_tuser,   // op
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // step_x/y/z, dir_x/y/z, run_x/y/z, pad
    // speed_limit write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SPEED_BITS-1:0]  cfg_data
);

    tasp_cmd_t  cmd;
    tasp_stat_t stat;

    // register write never stalls
    assign cfg_ready = 1'b1;

    tasp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    tasp_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_steps  (s_axis_tdata[AXES*STEP_BITS-1:0]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_data),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: hw/rtl/tasp_checker.sv
// ---------------------------------------------------------------------------
// tasp_checker
// Port-level checks on the pulse generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "three_axis_step_pulse_generator_assert.svh"

module tasp_checker import tasp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // one item at a time: busy right after every accepted transfer
    `TASP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a stalled result holds
    `TASP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // a new result only appears at the end of work, never straight from idle
    `TASP_ASSERT_NOW(a_out_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind three_axis_step_pulse_generator tasp_checker u_tasp_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Step pulse generator stream testbench
// Drives ticks and step commands into the three-axis generator, tracks pin
// levels with its own predictor and compares every returned pin word field by
// field. The speed limit is stepped through several values, the extremes
// included. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tasp_pkg::*;

    localparam int   QUIET_LIMIT  = 2000;   // room for a command's division plus output stalls
    localparam int   SETTLE_TICKS = 150;
    localparam int   PRINT_CAP    = 60;

    // pin word as it sits in m_axis_tdata, lowest bit first: step x/y/z,
    // dir x/y/z, run x/y/z
    typedef struct packed {
        logic [2:0] run;
        logic [2:0] dir;
        logic [2:0] level;
    } pin_word_t;

    // ------------------------------------------------------------------------
    // Pin predictor and result store
    // ------------------------------------------------------------------------
    class step_pin_scoreboard;
        logic [SPEED_BITS-1:0] speed_limit = SPEED_LIMIT_RESET;
        logic [TIME_BITS-1:0]  elapsed_ticks = '0;
        logic [TIME_BITS-1:0]  frame_ticks = '0;
        logic [TIME_BITS-1:0]  toggle_period [3] = '{default: '0};
        logic [TIME_BITS-1:0]  phase_ticks [3] = '{default: '0};
        logic [2:0]            pin_level = '0;
        logic [2:0]            pin_dir = '0;
        logic [2:0]            axis_on = '0;
        pin_word_t             expected_pins [$];
        int unsigned           mismatches = 0;
        int unsigned           words_seen = 0;
        string pin_name [9] = '{"step_x", "step_y", "step_z", "dir_x", "dir_y", "dir_z",
                                "run_x", "run_y", "run_z"};

        function void set_speed_limit(logic [SPEED_BITS-1:0] value);
            speed_limit = value;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        // direction from the sign, magnitude clamped, period at least one tick
        function void start_axis(int a, logic [STEP_BITS-1:0] req);
            logic [STEP_BITS-1:0] mag;
            mag = req[STEP_BITS-1] ? (~req + 1'b1) : req;
            pin_dir[a] = req[STEP_BITS-1];
            if (mag > STEP_BITS'(speed_limit))
                mag = STEP_BITS'(speed_limit);
            if (mag == '0)
            begin
                axis_on[a] = 1'b0;
                return;
            end
            toggle_period[a] = frame_ticks / TIME_BITS'(mag);
            if (toggle_period[a] == '0)
                toggle_period[a] = 1;
            phase_ticks[a] = '0;
            axis_on[a] = 1'b1;
        endfunction

        function void note_transfer(logic op, logic [IN_TDATA_W-1:0] word);
            if (op == OP_COMMAND)
            begin
                frame_ticks = elapsed_ticks;
                elapsed_ticks = '0;
                for (int a = 0; a < 3; a++)
                    start_axis(a, word[a*STEP_BITS +: STEP_BITS]);
            end
            else
            begin
                if (elapsed_ticks != '1)
                    elapsed_ticks++;
                for (int a = 0; a < 3; a++)
                begin
                    if (!axis_on[a])
                        continue;
                    phase_ticks[a]++;
                    if (phase_ticks[a] < toggle_period[a])
                        continue;
                    phase_ticks[a] = '0;
                    pin_level[a] = ~pin_level[a];
                    // overdue frame: everything stops, later axes skip this tick
                    if ({2'b00, elapsed_ticks} > {1'b0, frame_ticks, 1'b0})
                        axis_on = '0;
                end
            end
            expected_pins.push_back('{run: axis_on, dir: pin_dir, level: pin_level});
        endfunction

        task report(string msg);
            if (mismatches < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_pins(logic [8:0] got);
            pin_word_t want;
            words_seen++;
            if (expected_pins.size() == 0)
            begin
                report($sformatf("pin word %0d (%b) arrived with nothing expected",
                                 words_seen, got));
                return;
            end
            want = expected_pins.pop_front();
            for (int i = 0; i < 9; i++)
                if (got[i] !== want[i])
                    report($sformatf("pin word %0d %s: got %b, expected %b",
                                     words_seen, pin_name[i], got[i], want[i]));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;    // steps_x, steps_y, steps_z
    logic                   s_axis_tuser;    // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;    // step_x/y/z, dir_x/y/z, run_x/y/z, pad
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SPEED_BITS-1:0]  cfg_data;        // speed_limit

    step_pin_scoreboard     sb = new;
    logic [SPEED_BITS-1:0]  cur_speed = SPEED_LIMIT_RESET;
    bit                     calm = 1'b0;     // no idling on either side
    int                     quiet_cycles = 0;

    always #6 clk = ~clk;

    three_axis_step_pulse_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: every transfer is seen at the edge that completes it. The input
    // is noted before the output is checked, so a result leaving at the same
    // edge still meets the older expectation at the head of the queue.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_transfer(s_axis_tuser, s_axis_tdata);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_pins(m_axis_tdata[8:0]);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.set_speed_limit(cfg_data);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog: too long without any transfer on any channel
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: ready drops in bursts, held high once things calm down
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Valid stays high from one transfer into the next; it only drops for a gap,
    // so it never gets two updates in one step.
    task automatic send_item(input logic op, input logic [IN_TDATA_W-1:0] word);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [IN_TDATA_W-1:0] random_word();
        return IN_TDATA_W'({$urandom(), $urandom()});
    endfunction

    // step fields carry junk on a tick; the block must ignore them
    task automatic send_ticks(input int count);
        repeat (count) send_item(OP_TICK, random_word());
    endtask

    task automatic send_command(input logic [STEP_BITS-1:0] x,
                                input logic [STEP_BITS-1:0] y,
                                input logic [STEP_BITS-1:0] z);
        send_item(OP_COMMAND, IN_TDATA_W'({z, y, x}));
    endtask

    // mostly small counts so periods stay short, some near the clamp,
    // some full range and the signed extremes
    function automatic logic [STEP_BITS-1:0] pick_step();
        int unsigned          roll;
        logic [STEP_BITS-1:0] mag;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            mag = STEP_BITS'($urandom_range(0, 12));
        else if (roll < 70)
            mag = STEP_BITS'(cur_speed) + STEP_BITS'($urandom_range(0, 2)) - 1'b1;
        else if (roll < 85)
            return STEP_BITS'($urandom());
        else
        begin
            case ($urandom_range(0, 3))
                0:       return {1'b1, {(STEP_BITS-1){1'b0}}};
                1:       return {1'b0, {(STEP_BITS-1){1'b1}}};
                2:       return '1;
                default: return '0;
            endcase
        end
        return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
    endfunction

    // stop sending and wait for every outstanding pin word
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // speed_limit may only change while the block sits idle
    task automatic write_speed_limit(input logic [SPEED_BITS-1:0] speed);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= speed;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_speed = speed;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [SPEED_BITS-1:0] phase_speed [6];
        int                    phase_items [6];
        int                    sent;
        int                    frame;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_TICK;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, speed limit at its reset value.
        // Ticks right after reset: nothing runs, step fields ignored.
        send_item(OP_TICK, '1);
        send_item(OP_TICK, '0);
        send_ticks(2);
        // frame of 4: x period 2, y most negative count clamped (period 1),
        // z zero steps stays stopped
        send_command(16'sd2, -16'sd32768, 16'sd0);
        // run on within twice the frame, so the overdue check stops no axis
        send_ticks(6);
        // largest positive count clamped, negative counts set dir
        send_command(16'sd32767, -16'sd1, -16'sd5);
        send_ticks(3);
        // back-to-back commands: restart with a zero frame, period raised to 1,
        // the first x toggle is already overdue so y and z skip that tick
        send_command(16'sd4, 16'sd1, 16'sd0);
        send_command(16'sd1, -16'sd2, 16'sd3);
        send_ticks(2);
        // all zero: every axis stops, levels kept
        send_command(16'sd0, 16'sd0, 16'sd0);
        send_item(OP_TICK, '0);
        send_command(-16'sd32768, -16'sd32768, -16'sd32768);
        send_ticks(2);

        // Random part: speed limit walks through its extremes, small values, its reset
        // value. Mostly well-formed frames (ticks then a command), some noise.
        phase_speed = '{SPEED_BITS'(32767), SPEED_BITS'(0), SPEED_BITS'(1),
                        SPEED_BITS'($urandom_range(2, 40)), SPEED_BITS'(3),
                        SPEED_LIMIT_RESET};
        phase_items = '{190, 80, 190, 190, 190, 190};
        for (int p = 0; p < 6; p++)
        begin
            write_speed_limit(phase_speed[p]);
            if (p == 5)
                calm = 1'b1;
            sent = 0;
            while (sent < phase_items[p])
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // long frames now and then, so one can run overdue against the frame before
                    frame = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                       : $urandom_range(0, 24);
                    send_ticks(frame);
                    send_command(pick_step(), pick_step(), pick_step());
                    sent += frame + 1;
                end
                else
                begin
                    send_item($urandom_range(0, 1) ? OP_COMMAND : OP_TICK, random_word());
                    sent++;
                end
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
